@@ design/triangle_min_path_sum_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the triangle path-sum update stage.
// Each macro expects signals named clk and rst_n in the using module.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MIN_PATH_SUM_CORE_ASSERT_SVH
`define TRIANGLE_MIN_PATH_SUM_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TMPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tmps_pkg.sv @@
// ----------------------------------------------------------------------------
// tmps_pkg
// Types and constants shared by the triangle minimum path sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmps_pkg;

    localparam int MAX_ROWS = 64;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W    = 7;
    localparam int ELEM_W   = 16;
    localparam int SUM_W    = 22;
    // Wide enough for both the row count register and MAX_ROWS itself.
    localparam int ROWS_W   = (CNT_W > ROW_W + 1) ? CNT_W : ROW_W + 1;

    typedef logic [ROW_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [ROWS_W-1:0]        rows_t;
    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // One element on its way from the sequencer to the update stage.
    typedef struct packed {
        logic  valid;
        idx_t  col;
        logic  row_zero;
        logic  col_zero;
        logic  col_last;
        logic  final_row;
        logic  is_end;
        elem_t elem;
    } ctl_t;

endpackage

`default_nettype wire

@@ design/tmps_in_if.sv @@
// ----------------------------------------------------------------------------
// tmps_in_if
// Request channel carrying one triangle element per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmps_in_if import tmps_pkg::*;;
    logic  valid;
    logic  ready;
    elem_t element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

`default_nettype wire

@@ design/tmps_out_if.sv @@
// ----------------------------------------------------------------------------
// tmps_out_if
// Result channel carrying the minimum path sum of a finished triangle.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmps_out_if import tmps_pkg::*;;
    logic valid;
    logic ready;
    sum_t min_total;

    modport source (output valid, output min_total, input ready);
    modport sink   (input valid, input min_total, output ready);
endinterface

`default_nettype wire

@@ design/tmps_sum_ram.sv @@
// ----------------------------------------------------------------------------
// tmps_sum_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmps_sum_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 22,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/tmps_seq.sv @@
// ----------------------------------------------------------------------------
// tmps_seq
// Row/column sequencer: holds the row count, tracks the position of the
// next element, issues the row-store read and stages the element.
// ----------------------------------------------------------------------------
`default_nettype none

module tmps_seq import tmps_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire cnt_t  cfg_wdata,
    tmps_in_if.sink    in_req,
    input  wire logic  out_busy,
    output logic       rd_en,
    output idx_t       rd_addr,
    output ctl_t       s1_reg
);

    cnt_t  row_count_reg;
    idx_t  row_reg, row_next;
    idx_t  col_reg, col_next;
    ctl_t  s1_next;
    rows_t rows_eff;
    rows_t row_plus;
    logic  final_row;
    logic  col_last;
    logic  in_end;
    logic  accept;

    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_eff = rows_t'(1);
        end
        else if (rows_t'(row_count_reg) > rows_t'(MAX_ROWS))
        begin
            rows_eff = rows_t'(MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_t'(row_count_reg);
        end
    end

    assign row_plus  = rows_t'(row_reg) + rows_t'(1);
    assign final_row = (row_plus >= rows_eff);
    assign col_last  = (col_reg == row_reg);
    assign in_end    = col_last && final_row;

    // The element that closes a triangle waits until the result buffer is
    // sure to have room when it reaches the update stage.
    assign in_req.ready = !(in_end && out_busy);
    assign accept       = in_req.valid && in_req.ready;

    assign rd_en   = accept;
    assign rd_addr = col_reg;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = final_row ? '0 : idx_t'(row_plus);
            end
            else
            begin
                col_next = col_reg + idx_t'(1);
            end
        end

        s1_next.valid     = accept;
        s1_next.col       = col_reg;
        s1_next.row_zero  = (row_reg == '0);
        s1_next.col_zero  = (col_reg == '0);
        s1_next.col_last  = col_last;
        s1_next.final_row = final_row;
        s1_next.is_end    = in_end;
        s1_next.elem      = in_req.element_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= cnt_t'(1);
            row_reg       <= '0;
            col_reg       <= '0;
            s1_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                row_count_reg <= cfg_wdata;
            end
            row_reg <= row_next;
            col_reg <= col_next;
            s1_reg  <= s1_next;
        end
    end

endmodule

`default_nettype wire

@@ design/tmps_update.sv @@
// ----------------------------------------------------------------------------
// tmps_update
// Update stage: forms the new path sum from the row-store read data, writes
// it back, tracks the final-row minimum and holds the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_min_path_sum_core_assert.svh"

module tmps_update import tmps_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire ctl_t  s1_reg,
    input  wire sum_t  rd_data,
    input  wire logic  rd_en,
    input  wire idx_t  rd_addr,
    output logic       wr_en,
    output idx_t       wr_addr,
    output sum_t       wr_data,
    output logic       out_busy,
    tmps_out_if.source out_rsp
);

    logic       fwd_reg, fwd_next;
    sum_t       fwd_data_reg;
    sum_t       left_old_reg, left_old_next;
    sum_t       min_reg, min_next;
    logic       out_valid_reg, out_valid_next;
    sum_t       out_data_reg, out_data_next;
    logic       spare_valid_reg, spare_valid_next;
    sum_t       spare_data_reg, spare_data_next;
    logic       pop;
    logic [1:0] occ;
    sum_t       above;
    sum_t       elem_ext;
    sum_t       pick;
    sum_t       sum;
    sum_t       run_min;

    // A write to the entry that is read in the same cycle is not seen by
    // the RAM read, so the written value is registered and used instead.
    assign above    = fwd_reg ? fwd_data_reg : rd_data;
    assign elem_ext = {{(SUM_W-ELEM_W){s1_reg.elem[ELEM_W-1]}}, s1_reg.elem};

    // Results sit in a two-entry buffer: the output register and a spare
    // behind it. Counting the result in the update stage and the one that
    // leaves at this edge, an element that closes a triangle may enter only
    // while at most one entry stays taken.
    assign pop      = out_valid_reg && out_rsp.ready;
    assign occ      = {1'b0, out_valid_reg} + {1'b0, spare_valid_reg}
                    + {1'b0, s1_reg.valid && s1_reg.is_end} - {1'b0, pop};
    assign out_busy = (occ > 2'd1);

    always_comb
    begin
        if (s1_reg.col_zero)
        begin
            pick = above;
        end
        else if (s1_reg.col_last)
        begin
            pick = left_old_reg;
        end
        else
        begin
            pick = (left_old_reg < above) ? left_old_reg : above;
        end
        sum = s1_reg.row_zero ? elem_ext : (pick + elem_ext);

        run_min = min_reg;
        if (s1_reg.final_row && (s1_reg.col_zero || (sum < min_reg)))
        begin
            run_min = sum;
        end

        left_old_next    = left_old_reg;
        min_next         = min_reg;
        out_valid_next   = out_valid_reg && !pop;
        out_data_next    = out_data_reg;
        spare_valid_next = spare_valid_reg;
        spare_data_next  = spare_data_reg;
        if (!out_valid_next)
        begin
            out_valid_next   = spare_valid_reg;
            out_data_next    = spare_data_reg;
            spare_valid_next = 1'b0;
        end
        if (s1_reg.valid)
        begin
            left_old_next = s1_reg.col_last ? '0 : above;
            min_next      = s1_reg.is_end ? '0 : run_min;
            if (s1_reg.is_end)
            begin
                if (out_valid_next)
                begin
                    spare_valid_next = 1'b1;
                    spare_data_next  = run_min;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = run_min;
                end
            end
        end

        fwd_next = s1_reg.valid && rd_en && (rd_addr == s1_reg.col);
    end

    assign wr_en   = s1_reg.valid;
    assign wr_addr = s1_reg.col;
    assign wr_data = sum;

    assign out_rsp.valid     = out_valid_reg;
    assign out_rsp.min_total = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg         <= 1'b0;
            left_old_reg    <= '0;
            min_reg         <= '0;
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_reg         <= fwd_next;
            left_old_reg    <= left_old_next;
            min_reg         <= min_next;
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg   <= sum;
        out_data_reg   <= out_data_next;
        spare_data_reg <= spare_data_next;
    end

    `TMPS_ASSERT_IMP(a_end_slot_free, s1_reg.valid && s1_reg.is_end, !spare_valid_reg || out_rsp.ready, "result buffer full when triangle ends")
    `TMPS_ASSERT_NXT(a_end_gives_result, s1_reg.valid && s1_reg.is_end, out_valid_reg, "finished triangle gave no result")
    `TMPS_ASSERT_IMP(a_spare_behind_head, spare_valid_reg, out_valid_reg, "spare result without a head result")
    `TMPS_ASSERT_IMP(a_fwd_col_zero, fwd_reg, s1_reg.valid && s1_reg.col_zero, "forwarding outside a row start")

endmodule

`default_nettype wire

@@ design/triangle_min_path_sum_core.sv @@
// ----------------------------------------------------------------------------
// triangle_min_path_sum_core
// Streams triangle elements in row-major order and returns the minimum
// top-to-bottom path sum of each triangle.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one signed 16-bit element per request, row by row; row r
//   has r+1 elements. out_rsp carries one signed 22-bit min_total per
//   finished triangle. cfg_we/cfg_wdata set the row count (1 to 64; zero
//   acts as one row, larger values as 64). Write it only while idle.
//   Throughput is one element per cycle unless the element that closes a
//   triangle is held back. Each element's row-store read is issued as it
//   is staged; the update stage then adds, compares and writes it back,
//   and registers the result when no earlier result is waiting.
//   The row store is a 64-entry RAM with one read and one write port; a
//   read of the entry being written in the same cycle is forwarded.
//   Results wait in a two-entry buffer while the next triangle keeps
//   streaming. Only the element that closes a triangle is held back (ready
//   low), and only while the buffer could not take its result, so a ready
//   receiver never slows the input, even with single-row triangles.
//   Reset brings the row count to one, the position to the top of a new
//   triangle and drops any pending result. The row store needs no clearing,
//   since every entry is written before it is used.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_min_path_sum_core import tmps_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire cnt_t  cfg_wdata,
    tmps_in_if.sink    in_req,
    tmps_out_if.source out_rsp
);

    ctl_t s1_reg;
    logic rd_en;
    idx_t rd_addr;
    sum_t rd_data;
    logic wr_en;
    idx_t wr_addr;
    sum_t wr_data;
    logic out_busy;

    // Position tracking and row-store read issue.
    tmps_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_req    (in_req),
        .out_busy  (out_busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .s1_reg    (s1_reg)
    );

    // One row of best path sums, updated in place left to right.
    tmps_sum_ram #(
        .DEPTH (MAX_ROWS),
        .WIDTH (SUM_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Add-min, write-back and result buffer.
    tmps_update u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_reg   (s1_reg),
        .rd_data  (rd_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .out_busy (out_busy),
        .out_rsp  (out_rsp)
    );

endmodule

`default_nettype wire
